>>> design/shared_buffer_multi_queue_assert.svh
// Assertion helpers for the shared buffer multi-queue block.
// Each macro samples on the rising edge of clk and is disabled while rst is high.
`ifndef SHARED_BUFFER_MULTI_QUEUE_ASSERT_SVH
`define SHARED_BUFFER_MULTI_QUEUE_ASSERT_SVH

// Same-cycle implication
`define SBMQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sbmq: same-cycle port check failed");

// Next-cycle implication
`define SBMQ_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sbmq: next-cycle port check failed");

`endif

>>> design/sbmq_pkg.sv
// ----------------------------------------------------------------------------
// sbmq_pkg
// Shared types and constants for the shared buffer multi-queue block.
// ----------------------------------------------------------------------------
package sbmq_pkg;

  localparam int ENTRIES_DEF = 64;
  localparam int QUEUES_DEF  = 4;
  localparam int DATA_W      = 32;
  localparam int QID_W       = 2;

  // operation codes
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // one result transfer
  typedef struct packed {
    logic              valid;
    status_t           status;
    logic [DATA_W-1:0] data;
    logic              queue_empty;
    logic              store_full;
  } result_t;

endpackage

>>> design/shared_buffer_multi_queue.sv
// ----------------------------------------------------------------------------
// shared_buffer_multi_queue
// Several FIFO queues sharing one entry store, threaded by a free list.
// ----------------------------------------------------------------------------
// A command (op, queue_id, value) transfers when start is high and busy is
// low. Busy is high for the cycle after the transfer, and the result
// appears on status/data/queue_empty/store_full with done high for exactly
// one cycle after that; the next command may transfer in that same cycle.
// A command is a registered read of the link and data memories followed
// by the write-back of the updated link, data word and pointers. The
// receiver cannot stall: a result is on the ports for that single done cycle
// only. No clearing pass follows reset; the initial free-list links are
// supplied by a fill mark, so commands are taken right after reset.
// queue_id is folded modulo QUEUES.
module shared_buffer_multi_queue #(
  parameter int ENTRIES = sbmq_pkg::ENTRIES_DEF,
  parameter int QUEUES  = sbmq_pkg::QUEUES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic                               op,
  input  logic [sbmq_pkg::QID_W-1:0]         queue_id,
  input  logic signed [sbmq_pkg::DATA_W-1:0] value,
  output logic                               busy,
  output logic                               done,
  output logic [1:0]                         status,
  output logic signed [sbmq_pkg::DATA_W-1:0] data,
  output logic                               queue_empty,
  output logic                               store_full
);

  localparam int AW = $clog2(ENTRIES);
  localparam int PW = $clog2(ENTRIES + 1);

  logic [AW-1:0]               link_raddr, link_waddr;
  logic [PW-1:0]               link_rdata, link_wdata;
  logic                        link_we;
  logic [AW-1:0]               data_raddr, data_waddr;
  logic [sbmq_pkg::DATA_W-1:0] data_rdata, data_wdata;
  logic                        data_we;
  sbmq_pkg::result_t           result;

  // next-entry links
  sbmq_ram #(.WIDTH(PW), .DEPTH(ENTRIES)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  // entry data words
  sbmq_ram #(.WIDTH(sbmq_pkg::DATA_W), .DEPTH(ENTRIES)) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (data_waddr),
    .wdata (data_wdata),
    .raddr (data_raddr),
    .rdata (data_rdata)
  );

  sbmq_ctrl #(.ENTRIES(ENTRIES), .QUEUES(QUEUES)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .op         (op),
    .queue_id   (queue_id),
    .value      (value),
    .busy       (busy),
    .link_raddr (link_raddr),
    .link_rdata (link_rdata),
    .link_we    (link_we),
    .link_waddr (link_waddr),
    .link_wdata (link_wdata),
    .data_raddr (data_raddr),
    .data_rdata (data_rdata),
    .data_we    (data_we),
    .data_waddr (data_waddr),
    .data_wdata (data_wdata),
    .result     (result)
  );

  // result ports
  assign done        = result.valid;
  assign status      = result.status;
  assign data        = result.data;
  assign queue_empty = result.queue_empty;
  assign store_full  = result.store_full;

endmodule

>>> design/sbmq_ram.sv
// ----------------------------------------------------------------------------
// sbmq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sbmq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/sbmq_ctrl.sv
// ----------------------------------------------------------------------------
// sbmq_ctrl
// Queue pointer control: head/tail/free-list registers, command sequencer and
// read-modify-write of the link and data memories.
// ----------------------------------------------------------------------------
module sbmq_ctrl #(
  parameter int ENTRIES = sbmq_pkg::ENTRIES_DEF,
  parameter int QUEUES  = sbmq_pkg::QUEUES_DEF,
  localparam int AW     = $clog2(ENTRIES),
  localparam int PW     = $clog2(ENTRIES + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        op,
  input  logic [sbmq_pkg::QID_W-1:0]  queue_id,
  input  logic [sbmq_pkg::DATA_W-1:0] value,
  output logic                        busy,
  // link memory
  output logic [AW-1:0]               link_raddr,
  input  logic [PW-1:0]               link_rdata,
  output logic                        link_we,
  output logic [AW-1:0]               link_waddr,
  output logic [PW-1:0]               link_wdata,
  // data memory
  output logic [AW-1:0]               data_raddr,
  input  logic [sbmq_pkg::DATA_W-1:0] data_rdata,
  output logic                        data_we,
  output logic [AW-1:0]               data_waddr,
  output logic [sbmq_pkg::DATA_W-1:0] data_wdata,
  output sbmq_pkg::result_t           result
);

  localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int VW = $clog2(QUEUES + 4);
  localparam logic [PW-1:0] NONE_P = PW'(ENTRIES);

  sbmq_pkg::state_t state, state_next;

  logic [PW-1:0] head [QUEUES];
  logic [PW-1:0] tail [QUEUES];
  logic [PW-1:0] free_head;
  logic [PW-1:0] wm;          // entries at or above this were never written

  logic                        op_r;
  logic [QW-1:0]               q_r;
  logic [sbmq_pkg::DATA_W-1:0] value_r;
  logic [PW-1:0]               rd_ptr;
  logic                        rd_fresh;

  logic [VW-1:0] qmod;
  logic [QW-1:0] q_in;
  logic [PW-1:0] rd_sel;
  logic          accept;
  logic          exec;

  logic [PW-1:0]         slot, head_cur, tail_cur, link_val;
  logic [PW-1:0]         head_new, tail_new, free_new, wm_new;
  logic                  slot_ok;
  sbmq_pkg::status_t     res_status;
  logic [sbmq_pkg::DATA_W-1:0] res_data;

  logic    res_valid;
  sbmq_pkg::result_t res_pay;

  // queue number folded below QUEUES
  always_comb begin
    qmod = VW'(queue_id);
    for (int i = 0; i < 3; i++) begin
      if (qmod >= VW'(QUEUES)) begin
        qmod = qmod - VW'(QUEUES);
      end
    end
  end
  assign q_in = qmod[QW-1:0];

  // read issue at accept: free-list head for enqueue, queue head for dequeue
  assign accept     = start && (state == sbmq_pkg::S_IDLE);
  assign rd_sel     = (op == sbmq_pkg::OP_DEQ) ? head[q_in] : free_head;
  assign link_raddr = rd_sel[AW-1:0];
  assign data_raddr = rd_sel[AW-1:0];

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sbmq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b0;
    exec       = 1'b0;
    case (state)
      sbmq_pkg::S_IDLE: begin
        if (start) begin
          state_next = sbmq_pkg::S_EXEC;
        end
      end
      sbmq_pkg::S_EXEC: begin
        busy       = 1'b1;
        exec       = 1'b1;
        state_next = sbmq_pkg::S_IDLE;
      end
      default: state_next = sbmq_pkg::S_IDLE;
    endcase
  end

  // command capture
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= op;
      q_r      <= q_in;
      value_r  <= value;
      rd_ptr   <= rd_sel;
      rd_fresh <= (rd_sel >= wm);
    end
  end

  // update of pointers and memory write-back
  always_comb begin
    slot     = rd_ptr;
    slot_ok  = (rd_ptr < NONE_P);
    head_cur = head[q_r];
    tail_cur = tail[q_r];
    // an untouched entry links to its successor
    link_val = rd_fresh ? (rd_ptr + PW'(1)) : link_rdata;

    head_new = head_cur;
    tail_new = tail_cur;
    free_new = free_head;
    wm_new   = wm;

    link_we    = 1'b0;
    link_waddr = slot[AW-1:0];
    link_wdata = free_head;
    data_we    = 1'b0;
    data_waddr = slot[AW-1:0];
    data_wdata = value_r;

    res_status = sbmq_pkg::ST_OK;
    res_data   = '0;

    if (op_r == sbmq_pkg::OP_ENQ) begin
      if (!slot_ok) begin
        res_status = sbmq_pkg::ST_FULL;
      end else begin
        free_new = link_val;
        if (rd_fresh) begin
          wm_new = wm + PW'(1);
        end
        if ((head_cur < NONE_P) && (tail_cur < NONE_P)) begin
          link_we    = exec;
          link_waddr = tail_cur[AW-1:0];
          link_wdata = slot;
        end else begin
          head_new = slot;
        end
        tail_new = slot;
        data_we  = exec;
      end
    end else begin
      if (!slot_ok) begin
        res_status = sbmq_pkg::ST_EMPTY;
        res_data   = '1;
      end else begin
        // tail's link is never relied on: the last entry is known by the tail
        head_new = (slot == tail_cur) ? NONE_P : link_val;
        if (head_new == NONE_P) begin
          tail_new = NONE_P;
        end
        link_we  = exec;
        free_new = slot;
        res_data = data_rdata;
      end
    end
  end

  // pointer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < QUEUES; i++) begin
        head[i] <= NONE_P;
        tail[i] <= NONE_P;
      end
      free_head <= '0;
      wm        <= '0;
      res_valid <= 1'b0;
    end else begin
      res_valid <= exec;
      if (exec) begin
        head[q_r] <= head_new;
        tail[q_r] <= tail_new;
        free_head <= free_new;
        wm        <= wm_new;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (exec) begin
      res_pay.valid       <= 1'b1;
      res_pay.status      <= res_status;
      res_pay.data        <= res_data;
      res_pay.queue_empty <= !(head_new < NONE_P);
      res_pay.store_full  <= !(free_new < NONE_P);
    end
  end

  assign result = '{valid:       res_valid,
                    status:      res_pay.status,
                    data:        res_pay.data,
                    queue_empty: res_pay.queue_empty,
                    store_full:  res_pay.store_full};

endmodule

>>> design/sbmq_checker.sv
// ----------------------------------------------------------------------------
// sbmq_checker
// Port-level timing and result-consistency checks, bound to the top level.
// ----------------------------------------------------------------------------
`include "shared_buffer_multi_queue_assert.svh"

module sbmq_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        done,
  input logic [1:0]                  status,
  input logic [sbmq_pkg::DATA_W-1:0] data,
  input logic                        queue_empty,
  input logic                        store_full
);

  // command transfer leads to one busy cycle, no stale result
  `SBMQ_ASSERT_NXT(a_accept_busy, start && !busy, busy && !done)

  // busy lasts one cycle and ends with a result
  `SBMQ_ASSERT_NXT(a_busy_done, busy, !busy && done)

  // refused enqueue reports a full store and zero data
  `SBMQ_ASSERT_NOW(a_full_flag, done && (status == sbmq_pkg::ST_FULL), store_full && (data == '0))

  // dequeue from an empty queue reports all ones and an empty queue
  `SBMQ_ASSERT_NOW(a_empty_data, done && (status == sbmq_pkg::ST_EMPTY), queue_empty && (&data))

endmodule

bind shared_buffer_multi_queue sbmq_checker u_sbmq_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .status      (status),
  .data        (data),
  .queue_empty (queue_empty),
  .store_full  (store_full)
);
